// ----- hdl/esc_pkg.sv -----
// Shared types and constants for the escape sequence decoder.
package esc_pkg;

  // Largest number of output words that one input word can produce.
  localparam int MaxBurst = 4;

  // A group of decoded words from one input word, first word in data[0].
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] data;
    logic [2:0]               cnt;
  } burst_t;

endpackage

// ----- hdl/esc_if.sv -----
// Stream interfaces for the source string words and the decoded words.
interface esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- hdl/esc_dec.sv -----
// Escape decoder: sequence state registers and the per-word decode logic.
module esc_dec (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      in_byte,
  input  logic            final_byte,
  output esc_pkg::burst_t burst
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_OCT    = 3'd2;
  localparam logic [2:0] MODE_HEX    = 3'd3;
  localparam logic [2:0] MODE_UNI    = 3'd4;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_LE  = 8'h65;
  localparam logic [7:0] CH_UE  = 8'h45;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_LU  = 8'h75;
  localparam logic [7:0] CH_UU  = 8'h55;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // Encode a code point as UTF-8, or as the bare letter when it is not valid.
  function automatic esc_pkg::burst_t utf8_enc(input logic [31:0] cp, input logic lf);
    esc_pkg::burst_t b;
    b.data = '0;
    if (cp > 32'h0010_FFFF || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF)) begin
      b.data[0] = lf ? CH_UU : CH_LU;
      b.cnt     = 3'd1;
    end else if (cp <= 32'h0000_007F) begin
      b.data[0] = cp[7:0];
      b.cnt     = 3'd1;
    end else if (cp <= 32'h0000_07FF) begin
      b.data[0] = 8'hC0 | {3'b000, cp[10:6]};
      b.data[1] = 8'h80 | {2'b00, cp[5:0]};
      b.cnt     = 3'd2;
    end else if (cp <= 32'h0000_FFFF) begin
      b.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
      b.data[1] = 8'h80 | {2'b00, cp[11:6]};
      b.data[2] = 8'h80 | {2'b00, cp[5:0]};
      b.cnt     = 3'd3;
    end else begin
      b.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
      b.data[1] = 8'h80 | {2'b00, cp[17:12]};
      b.data[2] = 8'h80 | {2'b00, cp[11:6]};
      b.data[3] = 8'h80 | {2'b00, cp[5:0]};
      b.cnt     = 3'd4;
    end
    return b;
  endfunction

  logic [2:0]  mode;
  logic [2:0]  mode_next;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [3:0]  dig;
  logic [3:0]  dig_next;
  logic        long_form;
  logic        long_form_next;

  logic        is_hex;
  logic        is_oct;
  logic [3:0]  hval;
  logic [31:0] acc_oct;
  logic [31:0] acc_uni;
  logic [3:0]  dig_inc;
  logic [3:0]  need;
  logic [7:0]  letter_u;
  logic        do_fresh;

  // Classify the incoming word as a hex or octal digit.
  always_comb begin
    is_hex = 1'b1;
    hval   = in_byte[3:0];
    if (in_byte inside {[8'h30:8'h39]}) begin
      hval = in_byte[3:0];
    end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hval = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    is_oct = in_byte inside {[8'h30:8'h37]};
  end

  assign acc_oct  = {acc[28:0], in_byte[2:0]};
  assign acc_uni  = {acc[27:0], hval};
  assign dig_inc  = dig + 4'd1;
  assign need     = long_form ? 4'd8 : 4'd4;
  assign letter_u = long_form ? CH_UU : CH_LU;

  // Decode one word: the words it produces and the sequence state it leaves.
  always_comb begin
    burst          = '0;
    mode_next      = MODE_NORMAL;
    acc_next       = '0;
    dig_next       = '0;
    long_form_next = 1'b0;
    do_fresh       = 1'b0;
    case (mode)
      MODE_ESC: begin
        burst.cnt = 3'd1;
        case (in_byte)
          CH_A:   burst.data[0] = 8'h07;
          CH_B:   burst.data[0] = 8'h08;
          CH_F:   burst.data[0] = 8'h0C;
          CH_N:   burst.data[0] = 8'h0A;
          CH_R:   burst.data[0] = 8'h0D;
          CH_T:   burst.data[0] = 8'h09;
          CH_V:   burst.data[0] = 8'h0B;
          CH_BSL, CH_SQ, CH_DQ: burst.data[0] = in_byte;
          CH_LE, CH_UE: burst.data[0] = CH_ESC;
          CH_X: begin
            if (final_byte) begin
              burst.data[0] = in_byte;
            end else begin
              burst.cnt = 3'd0;
              mode_next = MODE_HEX;
            end
          end
          CH_LU, CH_UU: begin
            if (final_byte) begin
              burst.data[0] = in_byte;
            end else begin
              burst.cnt      = 3'd0;
              mode_next      = MODE_UNI;
              long_form_next = (in_byte == CH_UU);
            end
          end
          default: begin
            if (is_oct) begin
              if (final_byte) begin
                burst.data[0] = {5'b00000, in_byte[2:0]};
              end else begin
                burst.cnt = 3'd0;
                mode_next = MODE_OCT;
                acc_next  = {29'd0, in_byte[2:0]};
                dig_next  = 4'd1;
              end
            end else begin
              // Unknown escape passes through with its backslash.
              burst.data[0] = CH_BSL;
              burst.data[1] = in_byte;
              burst.cnt     = 3'd2;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (is_oct) begin
          if (dig_inc >= 4'd3 || final_byte) begin
            burst.data[0] = acc_oct[7:0];
            burst.cnt     = 3'd1;
          end else begin
            mode_next = MODE_OCT;
            acc_next  = acc_oct;
            dig_next  = dig_inc;
          end
        end else begin
          burst.data[0] = acc[7:0];
          burst.cnt     = 3'd1;
          do_fresh      = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          if (dig == 4'd0) begin
            if (final_byte) begin
              burst.data[0] = {4'h0, hval};
              burst.cnt     = 3'd1;
            end else begin
              mode_next = MODE_HEX;
              acc_next  = {28'd0, hval};
              dig_next  = 4'd1;
            end
          end else begin
            burst.data[0] = {acc[3:0], hval};
            burst.cnt     = 3'd1;
          end
        end else begin
          // A hex escape with no digit gives back the letter x in place of a value.
          burst.data[0] = (dig == 4'd0) ? CH_X : acc[7:0];
          burst.cnt     = 3'd1;
          do_fresh      = 1'b1;
        end
      end
      MODE_UNI: begin
        if (is_hex) begin
          if (dig_inc >= need) begin
            burst = utf8_enc(acc_uni, long_form);
          end else if (final_byte) begin
            burst.data[0] = letter_u;
            burst.cnt     = 3'd1;
          end else begin
            mode_next      = MODE_UNI;
            acc_next       = acc_uni;
            dig_next       = dig_inc;
            long_form_next = long_form;
          end
        end else begin
          burst.data[0] = letter_u;
          burst.cnt     = 3'd1;
          do_fresh      = 1'b1;
        end
      end
      default: do_fresh = 1'b1;
    endcase

    // The word that ends a sequence, or any word in normal mode, starts afresh.
    if (do_fresh) begin
      if (in_byte == CH_BSL && !final_byte) begin
        mode_next = MODE_ESC;
      end else begin
        burst.data[burst.cnt[1:0]] = in_byte;
        burst.cnt = burst.cnt + 3'd1;
      end
    end
  end

  // Sequence state advances once per decoded word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      acc       <= '0;
      dig       <= '0;
      long_form <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      acc       <= acc_next;
      dig       <= dig_next;
      long_form <= long_form_next;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_NORMAL || mode == MODE_ESC) |-> (dig == 4'd0 && acc == 32'd0 && !long_form))
    else $error("idle or escape state holds stale digits");

  a_oct_count: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_OCT |-> (dig == 4'd1 || dig == 4'd2))
    else $error("octal digit count out of range");

  a_uni_count: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_UNI |-> dig < need)
    else $error("unicode sequence kept past its digit count");

  a_burst_size: assert property (@(posedge clk) disable iff (rst)
    burst.cnt <= 3'd4)
    else $error("decoded group larger than four words");

endmodule

// ----- hdl/esc_ser.sv -----
// Result register that hands out a decoded group one word per cycle while out_stream is ready.
module esc_ser (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  esc_pkg::burst_t burst,
  output logic            free,
  esc_out_if.source       out_stream
);

  esc_pkg::burst_t hold;
  logic [1:0]      idx;
  logic            busy;
  logic            last;
  logic            take;

  assign last                = ({1'b0, idx} == hold.cnt - 3'd1);
  assign take                = busy && out_stream.ready;
  assign free                = !busy || (take && last);
  assign out_stream.valid    = busy;
  assign out_stream.out_byte = hold.data[idx];
  assign out_stream.run_last = last;

  // Control: load a new group once the current one has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (free) begin
      busy <= load;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  // Payload of the group being sent.
  always_ff @(posedge clk) begin
    if (free && load) begin
      hold <= burst;
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (hold.cnt != 3'd0 && {1'b0, idx} < hold.cnt))
    else $error("word index outside the held group");

  a_keep_group: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> (busy && idx == $past(idx) + 2'd1))
    else $error("group dropped before its last word");

endmodule

// ----- hdl/escape_sequence_decoder_utf8.sv -----
// Decodes C-style backslash escapes in a byte string into bytes, with \u and
// \U code points sent as UTF-8. One input word is taken per cycle into an
// input register while the input side is not held; it is decoded there
// combinationally and its 0 to 4 output words go to a result register, from
// which the first output word is offered. The result register sends one word
// per cycle while out_stream is ready, so an input that yields n words (n up
// to 4) holds the input side until the last of them is leaving; an input that
// yields no word moves on without waiting.
// run_last marks the last output word caused by an input word.
module escape_sequence_decoder_utf8 (
  input  logic      clk,
  input  logic      rst,
  esc_in_if.sink    in_stream,
  esc_out_if.source out_stream
);

  logic            iv;
  logic [7:0]      ib;
  logic            ifin;
  logic            adv;
  logic            ser_free;
  esc_pkg::burst_t burst;

  // The input word moves on when the result register can take its group, or when it yields no word.
  assign adv             = iv && (ser_free || burst.cnt == 3'd0);
  assign in_stream.ready = !iv || adv;

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_stream.ready) begin
      iv <= in_stream.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      ib   <= in_stream.in_byte;
      ifin <= in_stream.final_byte;
    end
  end

  esc_dec u_dec (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .in_byte    (ib),
    .final_byte (ifin),
    .burst      (burst)
  );

  esc_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (adv && burst.cnt != 3'd0),
    .burst      (burst),
    .free       (ser_free),
    .out_stream (out_stream)
  );

endmodule
